/* rtl/assert_macros.svh */
// Assertion macros used by the RTL of the scene text tokenizer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Plain property checked on every clock while out of reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Overlapped or next-cycle implication, written by the caller inside cons.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg)
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

/* rtl/stt_pkg.sv */
// Shared types and constants of the scene text tokenizer.
`timescale 1ns / 1ps
package stt_pkg;

  // input modes
  localparam logic [1:0] MODE_CHAR = 2'd0;
  localparam logic [1:0] MODE_EOL  = 2'd1;
  localparam logic [1:0] MODE_EOF  = 2'd2;

  // event codes
  localparam logic [3:0] EV_NONE        = 4'd0;
  localparam logic [3:0] EV_CHAR        = 4'd1;
  localparam logic [3:0] EV_TOKEN_END   = 4'd2;
  localparam logic [3:0] EV_STMT_END    = 4'd3;
  localparam logic [3:0] EV_BLOCK_BEGIN = 4'd4;
  localparam logic [3:0] EV_BLOCK_END   = 4'd5;
  localparam logic [3:0] EV_BAD_HEADER  = 4'd6;
  localparam logic [3:0] EV_INCOMPLETE  = 4'd7;
  localparam logic [3:0] EV_HALTED      = 4'd8;

  // special characters
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;

  // most results one input beat can cause
  localparam int MAX_RES = 3;

  // one result beat
  typedef struct packed {
    logic [3:0]  event_res;
    logic [7:0]  out_char;
    logic [7:0]  header_tokens;
    logic [15:0] line_index;
    logic        last;
  } stt_res_t;

endpackage

/* rtl/stt_if.sv */
// Valid/ready channel interfaces for tokenizer input and result beats.
`timescale 1ns / 1ps
interface stt_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] char_code;
  modport source (output valid, output mode, output char_code, input ready);
  modport sink (input valid, input mode, input char_code, output ready);
endinterface

interface stt_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  event_res;
  logic [7:0]  out_char;
  logic [7:0]  header_tokens;
  logic [15:0] line_index;
  logic        last;
  modport source (output valid, output event_res, output out_char, output header_tokens,
                  output line_index, output last, input ready);
  modport sink (input valid, input event_res, input out_char, input header_tokens,
                input line_index, input last, output ready);
endinterface

/* rtl/scene_text_tokenizer_top.sv */
// Scene text tokenizer: character stream in, tokenizer event beats out.
// Usage:
//  - in_if carries one beat per character, end of line or end of file
//    (mode, char_code); out_if carries event beats, last marks the final
//    beat caused by one input beat.
//  - Each input beat is decoded in the cycle it is accepted; its one to
//    three results sit in a three-entry result buffer and appear on out_if
//    from the next cycle, one per cycle while out_if.ready is high.
//  - Throughput: one input beat per cycle while each gives one result and
//    out_if.ready is high; a beat with k results holds the output until all
//    k leave, so the single output port draining the buffer sets the rate.
//  - in_if.ready is high when the buffer is empty or its last entry
//    leaves in the same cycle.
//  - When out_if.ready is low, results hold and input stalls while any
//    result beat waits in the buffer.
//  - Synchronous reset (rst_n low) clears all parser state, the line
//    count and the halted flag, and empties the result buffer.
//  - After bad header or incomplete errors every beat answers halted.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module scene_text_tokenizer_top
  import stt_pkg::*;
#(
  parameter int MAX_STMT_TOKENS = 255,
  parameter int LINE_BITS       = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  stt_in_if.sink     in_if,
  stt_out_if.source  out_if
);

  localparam int STW = $clog2(MAX_STMT_TOKENS + 1);

  // parser state
  logic                 esc_r, esc_nxt;
  logic                 quote_r, quote_nxt;
  logic                 tok_r, tok_nxt;
  logic                 block_r, block_nxt;
  logic                 skip_r, skip_nxt;
  logic                 halted_r, halted_nxt;
  logic [STW-1:0]       stmt_r, stmt_nxt;
  logic [LINE_BITS-1:0] line_r, line_nxt;

  // result buffer
  stt_res_t   res_r [MAX_RES];
  stt_res_t   res_nxt [MAX_RES];
  logic [1:0] cnt_r, cnt_nxt;

  // decode of the current input beat
  stt_res_t   new_res [MAX_RES];
  logic [1:0] n_res;
  logic [STW-1:0] tok_after;
  logic [7:0]  hdr_sat;
  logic [15:0] line_sat;
  logic        accept, pop;

  assign in_if.ready = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_if.ready);
  assign accept = in_if.valid && in_if.ready;
  assign pop    = out_if.valid && out_if.ready;

  // token count after a pending token is closed
  assign tok_after = (tok_r && (stmt_r < STW'(MAX_STMT_TOKENS))) ? stmt_r + 1'b1 : stmt_r;
  assign hdr_sat  = (32'(tok_after) > 32'd255) ? 8'hFF : 8'(tok_after);
  assign line_sat = (32'(line_r) > 32'd65535) ? 16'hFFFF : 16'(line_r);

  // single-pass decode: next state and result list
  always_comb begin
    esc_nxt    = esc_r;
    quote_nxt  = quote_r;
    tok_nxt    = tok_r;
    block_nxt  = block_r;
    skip_nxt   = skip_r;
    halted_nxt = halted_r;
    stmt_nxt   = stmt_r;
    line_nxt   = line_r;
    n_res      = 2'd0;
    for (int i = 0; i < MAX_RES; i++) begin
      new_res[i] = '{event_res: EV_NONE, out_char: 8'h00, header_tokens: 8'h00,
                     line_index: line_sat, last: 1'b0};
    end

    if (halted_r) begin
      new_res[n_res].event_res = EV_HALTED;
      n_res = n_res + 2'd1;
    end else begin
      case (in_if.mode)
        MODE_CHAR: begin
          if (skip_r) begin
            // comment text dropped
          end else if (esc_r) begin
            esc_nxt = 1'b0;
            tok_nxt = 1'b1;
            new_res[n_res].event_res = EV_CHAR;
            new_res[n_res].out_char  = in_if.char_code;
            n_res = n_res + 2'd1;
          end else if (in_if.char_code == CH_QUOTE) begin
            quote_nxt = !quote_r;
          end else if (quote_r) begin
            tok_nxt = 1'b1;
            new_res[n_res].event_res = EV_CHAR;
            new_res[n_res].out_char  = in_if.char_code;
            n_res = n_res + 2'd1;
          end else if (in_if.char_code == CH_HASH) begin
            skip_nxt = 1'b1;
          end else if (in_if.char_code inside {CH_SPACE, CH_TAB}) begin
            if (tok_r) begin
              tok_nxt  = 1'b0;
              stmt_nxt = tok_after;
              new_res[n_res].event_res = EV_TOKEN_END;
              n_res = n_res + 2'd1;
            end
          end else if (in_if.char_code == CH_LBRACE) begin
            tok_nxt  = 1'b0;
            stmt_nxt = tok_after;
            if (tok_r) begin
              new_res[n_res].event_res = EV_TOKEN_END;
              n_res = n_res + 2'd1;
            end
            new_res[n_res].header_tokens = hdr_sat;
            if ((tok_after == STW'(1)) || (tok_after == STW'(2))) begin
              stmt_nxt  = '0;
              block_nxt = 1'b1;
              new_res[n_res].event_res = EV_BLOCK_BEGIN;
            end else begin
              halted_nxt = 1'b1;
              new_res[n_res].event_res = EV_BAD_HEADER;
            end
            n_res = n_res + 2'd1;
          end else if (in_if.char_code == CH_RBRACE) begin
            tok_nxt   = 1'b0;
            stmt_nxt  = '0;
            block_nxt = 1'b0;
            if (tok_r) begin
              new_res[n_res].event_res = EV_TOKEN_END;
              n_res = n_res + 2'd1;
            end
            if (tok_after != '0) begin
              new_res[n_res].event_res = EV_STMT_END;
              n_res = n_res + 2'd1;
            end
            new_res[n_res].event_res = EV_BLOCK_END;
            n_res = n_res + 2'd1;
          end else if (in_if.char_code == CH_BSLASH) begin
            esc_nxt = 1'b1;
          end else begin
            tok_nxt = 1'b1;
            new_res[n_res].event_res = EV_CHAR;
            new_res[n_res].out_char  = in_if.char_code;
            n_res = n_res + 2'd1;
          end
        end
        MODE_EOL: begin
          tok_nxt  = 1'b0;
          skip_nxt = 1'b0;
          stmt_nxt = tok_after;
          if (tok_r) begin
            new_res[n_res].event_res = EV_TOKEN_END;
            n_res = n_res + 2'd1;
          end
          if (esc_r) begin
            // escaped newline joins lines
            esc_nxt = 1'b0;
          end else begin
            if (block_r && (tok_after != '0)) begin
              stmt_nxt = '0;
              new_res[n_res].event_res = EV_STMT_END;
              n_res = n_res + 2'd1;
            end
            if (line_r != '1) begin
              line_nxt = line_r + 1'b1;
            end
          end
        end
        MODE_EOF: begin
          tok_nxt  = 1'b0;
          stmt_nxt = tok_after;
          if (tok_r) begin
            new_res[n_res].event_res = EV_TOKEN_END;
            n_res = n_res + 2'd1;
          end
          if (tok_after != '0) begin
            halted_nxt = 1'b1;
            new_res[n_res].event_res = EV_INCOMPLETE;
            n_res = n_res + 2'd1;
          end
        end
        default: begin
          // unused mode: no effect
        end
      endcase
    end

    // an input with no event still answers once
    if (n_res == 2'd0) begin
      n_res = 2'd1;
    end
    new_res[n_res - 2'd1].last = 1'b1;
  end

  // result buffer load and drain
  always_comb begin
    res_nxt = res_r;
    cnt_nxt = cnt_r;
    if (accept) begin
      res_nxt = new_res;
      cnt_nxt = n_res;
    end else if (pop) begin
      res_nxt[0] = res_r[1];
      res_nxt[1] = res_r[2];
      cnt_nxt    = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      esc_r    <= 1'b0;
      quote_r  <= 1'b0;
      tok_r    <= 1'b0;
      block_r  <= 1'b0;
      skip_r   <= 1'b0;
      halted_r <= 1'b0;
      stmt_r   <= '0;
      line_r   <= '0;
      cnt_r    <= 2'd0;
    end else begin
      if (accept) begin
        esc_r    <= esc_nxt;
        quote_r  <= quote_nxt;
        tok_r    <= tok_nxt;
        block_r  <= block_nxt;
        skip_r   <= skip_nxt;
        halted_r <= halted_nxt;
        stmt_r   <= stmt_nxt;
        line_r   <= line_nxt;
      end
      cnt_r <= cnt_nxt;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  // output beat is the buffer head
  assign out_if.valid         = (cnt_r != 2'd0);
  assign out_if.event_res     = res_r[0].event_res;
  assign out_if.out_char      = res_r[0].out_char;
  assign out_if.header_tokens = res_r[0].header_tokens;
  assign out_if.line_index    = res_r[0].line_index;
  assign out_if.last          = res_r[0].last;

  // checks
  `ASSERT_IMPLY(a_tail_is_last, clk, rst_n, (cnt_r == 2'd1), res_r[0].last,
                "only remaining result beat must carry last")
  `ASSERT_IMPLY(a_halt_sticky, clk, rst_n, halted_r, ##1 halted_r,
                "halted flag cleared without reset")
  `ASSERT_IMPLY(a_accept_shows, clk, rst_n, accept, ##1 out_if.valid,
                "accepted beat produced no result")

endmodule
